FILE: rtl/rf_phase_calibration_correct_macros.svh
// Assertion helpers shared by the calibration block.
// Both sample on clk and stand down while arst_n is low.
`ifndef RF_PHASE_CALIBRATION_CORRECT_MACROS_SVH
`define RF_PHASE_CALIBRATION_CORRECT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define RFPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RFPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rfpc_pkg.sv
`default_nettype none

package rfpc_pkg;

	localparam int CHANNELS      = 8;
	localparam int TABLE_ENTRIES = 64;

	localparam int FULL_TURN = 23040;

	localparam int CH_W    = 3;
	localparam int PHASE_W = 15;
	localparam int AMP_W   = 16;
	localparam int OFF_W   = 16;
	localparam int SLOPE_W = 24;
	localparam int TIDX_W  = 6;
	localparam int VAL_W   = 24;
	localparam int MASK_W  = 8;
	localparam int SIDX_W  = 6;

	localparam int IDX_W   = $clog2(TABLE_ENTRIES);
	localparam int DEPTH   = CHANNELS * 2 * TABLE_ENTRIES;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int DIFF_W  = AMP_W + 1;
	localparam int PROD_W  = DIFF_W + SLOPE_W;
	localparam int CAL_W   = PROD_W - 14;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = MASK_W;

	localparam logic [IDX_W-1:0] SEARCH_LO  = IDX_W'(1);
	localparam logic [IDX_W-1:0] SEARCH_HI  = IDX_W'(TABLE_ENTRIES - 2);
	localparam logic [IDX_W-1:0] SEARCH_MID = IDX_W'((TABLE_ENTRIES - 1) / 2);

	typedef enum logic {
		OP_COMPUTE = 1'b0,
		OP_LOAD    = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		KIND_AMP    = 2'd0,
		KIND_OFFSET = 2'd1,
		KIND_SLOPE  = 2'd2
	} tbl_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BYPASS   = 1'b0,
		CFG_AMP_MASK = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic                      op;
		logic [CH_W-1:0]           channel;
		logic [PHASE_W-1:0]        measured_phase;
		logic [AMP_W-1:0]          amplitude;
		logic                      table_bank;
		logic [1:0]                table_kind;
		logic [TIDX_W-1:0]         table_index;
		logic signed [VAL_W-1:0]   table_value;
	} in_word_t;

	typedef struct packed {
		logic [PHASE_W-1:0] calibrated_phase;
		logic [PHASE_W-1:0] relative_phase;
		logic [SIDX_W-1:0]  search_index;
	} out_word_t;

	typedef struct packed {
		logic signed [SLOPE_W-1:0] slope;
		logic signed [OFF_W-1:0]   offset;
	} corr_entry_t;

	function automatic logic [ADDR_W-1:0] tbl_addr(input logic [CH_W-1:0] ch,
			input logic bank, input logic [IDX_W-1:0] idx);
		return ADDR_W'((int'(ch) * 2 + int'(bank)) * TABLE_ENTRIES + int'(idx));
	endfunction

	// One turn added or removed at most, then clamp whatever is left over.
	function automatic logic [PHASE_W-1:0] wrap_clamp(input logic signed [CAL_W-1:0] v);
		logic signed [CAL_W-1:0] turn;
		logic signed [CAL_W-1:0] w;
		turn = CAL_W'(FULL_TURN);
		if (v < 0) begin
			w = v + turn;
		end else if (v >= turn) begin
			w = v - turn;
		end else begin
			w = v;
		end
		if (w < 0) begin
			w = '0;
		end else if (w > turn - CAL_W'(1)) begin
			w = turn - CAL_W'(1);
		end
		return w[PHASE_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/rfpc_tables.sv
`default_nettype none

module rfpc_tables
	import rfpc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              ld,
	input  wire in_word_t          ld_word,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic [AMP_W-1:0]       amp_rd,
	output corr_entry_t            corr_rd
);

	logic [AMP_W-1:0] amp_mem  [DEPTH];
	corr_entry_t      corr_mem [DEPTH];

	logic              idx_ok;
	logic              amp_we;
	logic              off_we;
	logic              slope_we;
	logic [ADDR_W-1:0] wr_addr;

	assign idx_ok  = 32'(ld_word.table_index) < TABLE_ENTRIES;
	assign wr_addr = tbl_addr(ld_word.channel, ld_word.table_bank,
		IDX_W'(ld_word.table_index));

	// Decode the target table; an unknown kind or an index past the end writes nothing.
	always_comb begin
		amp_we   = 1'b0;
		off_we   = 1'b0;
		slope_we = 1'b0;
		unique case (ld_word.table_kind)
			KIND_AMP:    amp_we   = ld && idx_ok;
			KIND_OFFSET: off_we   = ld && idx_ok;
			KIND_SLOPE:  slope_we = ld && idx_ok;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (amp_we) begin
			amp_mem[wr_addr] <= ld_word.table_value[AMP_W-1:0];
		end
		if (off_we) begin
			corr_mem[wr_addr].offset <= ld_word.table_value[OFF_W-1:0];
		end
		if (slope_we) begin
			corr_mem[wr_addr].slope <= ld_word.table_value[SLOPE_W-1:0];
		end
		amp_rd  <= amp_mem[rd_addr];
		corr_rd <= corr_mem[rd_addr];
	end

endmodule

`default_nettype wire

FILE: rtl/rf_phase_calibration_correct.sv
// Amplitude-dependent phase correction for up to eight RF channels. A load word writes one
// entry of the amplitude, offset or slope table of a channel's bank and gives no result. A
// compute word binary-searches the channel's amplitude table, one table read per cycle on
// the single read port of the table memories, in one to six steps for 64 entries; then the
// CORR, MUL, SUM, WRAP and REL states run before the next word is taken, and bypass runs
// only WRAP and REL. The tables hold nothing until loaded and need no clearing pass; the
// channel 0 reference phase resets to zero and follows every channel 0 result.
`default_nettype none

`include "rf_phase_calibration_correct_macros.svh"

module rf_phase_calibration_correct
	import rfpc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_word_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_word_t                  out_data
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SEARCH = 7'b0000010,
		S_CORR   = 7'b0000100,
		S_MUL    = 7'b0001000,
		S_SUM    = 7'b0010000,
		S_WRAP   = 7'b0100000,
		S_REL    = 7'b1000000
	} state_t;

	state_t state_q;

	logic                      bypass_q;
	logic [MASK_W-1:0]         amp_mask_q;
	logic [PHASE_W-1:0]        ref_q;

	logic [CH_W-1:0]           ch_q;
	logic                      bank_q;
	logic [PHASE_W-1:0]        phase_q;
	logic [AMP_W-1:0]          amp_in_q;
	logic [IDX_W-1:0]          lo_q;
	logic [IDX_W-1:0]          hi_q;
	logic [IDX_W-1:0]          mid_q;
	logic [IDX_W-1:0]          found_q;
	logic signed [DIFF_W-1:0]  diff_q;
	logic signed [SLOPE_W-1:0] slope_q;
	logic signed [OFF_W-1:0]   offset_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [CAL_W-1:0]   cal_pre_q;
	logic [PHASE_W-1:0]        cal_q;

	logic                      out_valid_q;
	out_word_t                 out_q;

	logic                      accept;
	logic                      ch_ok;
	logic                      is_load;
	logic [AMP_W-1:0]          amp_rd;
	corr_entry_t               corr_rd;

	logic                      eq;
	logic                      lt;
	logic [IDX_W-1:0]          lo_n;
	logic [IDX_W-1:0]          hi_n;
	logic [IDX_W:0]            sum_n;
	logic                      done;
	logic [IDX_W-1:0]          nxt;
	logic [IDX_W-1:0]          rd_idx;
	logic [ADDR_W-1:0]         rd_addr;
	logic                      out_load;
	logic signed [CAL_W-1:0]   rel_diff;
	logic [PHASE_W-1:0]        rel;

	assign in_stall  = state_q != S_IDLE;
	assign accept    = in_valid && !in_stall;
	assign ch_ok     = 32'(in_data.channel) < CHANNELS;
	assign is_load   = in_data.op == OP_LOAD;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// One search step: narrow the window on the entry just read.
	always_comb begin
		eq    = amp_in_q == amp_rd;
		lt    = amp_in_q < amp_rd;
		lo_n  = lt ? lo_q : mid_q + IDX_W'(1);
		hi_n  = lt ? mid_q - IDX_W'(1) : hi_q;
		sum_n = {1'b0, lo_n} + {1'b0, hi_n};
		done  = eq || (lo_n > hi_n);
		nxt   = eq ? mid_q : sum_n[IDX_W:1];
	end

	// The table read runs every cycle; the sequencer uses the data where it needs it.
	assign rd_idx  = (state_q == S_IDLE) ? SEARCH_MID : nxt;
	assign rd_addr = (state_q == S_IDLE)
		? tbl_addr(in_data.channel, amp_mask_q[in_data.channel], rd_idx)
		: tbl_addr(ch_q, bank_q, rd_idx);

	rfpc_tables u_tables (
		.clk     (clk),
		.ld      (accept && ch_ok && is_load),
		.ld_word (in_data),
		.rd_addr (rd_addr),
		.amp_rd  (amp_rd),
		.corr_rd (corr_rd)
	);

	assign rel_diff = signed'(CAL_W'(cal_q)) - signed'(CAL_W'(ref_q));
	assign rel      = (ch_q == '0) ? cal_q : wrap_clamp(rel_diff);
	assign out_load = (state_q == S_REL) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q   <= 1'b0;
			amp_mask_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BYPASS:   bypass_q   <= cfg_data[0];
				CFG_AMP_MASK: amp_mask_q <= cfg_data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && ch_ok && !is_load) begin
						state_q <= bypass_q ? S_WRAP : S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (done) begin
						state_q <= S_CORR;
					end
				end
				S_CORR:  state_q <= S_MUL;
				S_MUL:   state_q <= S_SUM;
				S_SUM:   state_q <= S_WRAP;
				S_WRAP:  state_q <= S_REL;
				S_REL: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				ch_q      <= in_data.channel;
				bank_q    <= amp_mask_q[in_data.channel];
				phase_q   <= in_data.measured_phase;
				amp_in_q  <= in_data.amplitude;
				lo_q      <= SEARCH_LO;
				hi_q      <= SEARCH_HI;
				mid_q     <= SEARCH_MID;
				found_q   <= '0;
				cal_pre_q <= signed'(CAL_W'(in_data.measured_phase));
			end
			S_SEARCH: begin
				lo_q    <= lo_n;
				hi_q    <= hi_n;
				mid_q   <= nxt;
				found_q <= nxt;
			end
			S_CORR: begin
				diff_q   <= signed'({1'b0, amp_in_q}) - signed'({1'b0, amp_rd});
				slope_q  <= corr_rd.slope;
				offset_q <= corr_rd.offset;
			end
			S_MUL: begin
				prod_q <= PROD_W'(diff_q) * PROD_W'(slope_q);
			end
			S_SUM: begin
				// Arithmetic shift floors toward minus infinity.
				cal_pre_q <= signed'(CAL_W'(phase_q))
					- (CAL_W'(offset_q) + CAL_W'(prod_q >>> 16));
			end
			S_WRAP: begin
				cal_q <= wrap_clamp(cal_pre_q);
			end
			S_REL: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ref_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (out_load && ch_q == '0) begin
				ref_q <= cal_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.calibrated_phase <= cal_q;
			out_q.relative_phase   <= rel;
			out_q.search_index     <= SIDX_W'(found_q);
		end
	end

	`RFPC_ASSERT_NOW(a_search_window, state_q == S_SEARCH, lo_q <= hi_q, "search window empty while reading")
	`RFPC_ASSERT_NOW(a_found_range, state_q == S_CORR, found_q <= SEARCH_HI, "search index beyond last entry")
	`RFPC_ASSERT_NOW(a_word_source, $rose(out_valid_q), $past(state_q == S_REL), "result word without a finished item")
	`RFPC_ASSERT_NOW(a_ref_update, !$stable(ref_q), $past(out_load && ch_q == '0), "reference moved outside a channel 0 result")
	`RFPC_ASSERT_NEXT(a_phase_range, out_load, out_q.calibrated_phase <= PHASE_W'(FULL_TURN - 1), "calibrated phase out of turn")

endmodule

`default_nettype wire
